@@ sv/tga_psd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tga_psd_pkg;

    // Field widths fixed by the stream format and the result layout
    localparam int BYTE_W      = 8;
    localparam int PIXEL_X_W   = 12;
    localparam int PIXEL_Y_W   = 13;
    localparam int LINE_W      = 13;
    localparam int DIM_W       = 13;
    localparam int OFFSET_W    = 12;
    localparam int HDR_CNT_W   = 5;
    localparam int PIX_BYTES_W = 3;
    localparam int BYTE_IDX_W  = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;

    // Header layout
    localparam logic [HDR_CNT_W-1:0] HEADER_LEN    = 5'd18;
    localparam logic [HDR_CNT_W-1:0] HDR_ID_LEN    = 5'd0;
    localparam logic [HDR_CNT_W-1:0] HDR_DEPTH     = 5'd16;

    // Bytes per pixel codes
    localparam logic [PIX_BYTES_W-1:0] PIX_BYTES_NONE = 3'd0;
    localparam logic [PIX_BYTES_W-1:0] PIX_BYTES_BGR  = 3'd3;
    localparam logic [PIX_BYTES_W-1:0] PIX_BYTES_BGRA = 3'd4;

    localparam logic [LINE_W-1:0]    LINE_MAX     = 13'd8191;
    localparam logic [BYTE_W-1:0]    ALPHA_OPAQUE = 8'hFF;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET   = 2'd2;

    localparam logic [DIM_W-1:0]     LINE_WIDTH_RST   = 13'd640;
    localparam logic [DIM_W-1:0]     IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [OFFSET_W-1:0]  ROW_OFFSET_RST   = 12'd0;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              restart;
    } tga_in_t;

    typedef struct packed {
        logic [PIXEL_X_W-1:0] pixel_x;
        logic [PIXEL_Y_W-1:0] pixel_y;
        logic [BYTE_W-1:0]    red;
        logic [BYTE_W-1:0]    green;
        logic [BYTE_W-1:0]    blue;
        logic [BYTE_W-1:0]    alpha;
        logic                 in_image;
        logic                 line_end;
        logic                 depth_error;
    } tga_out_t;

    typedef struct packed {
        logic [DIM_W-1:0]    line_width;
        logic [DIM_W-1:0]    image_height;
        logic [OFFSET_W-1:0] row_offset;
    } tga_cfg_t;

    // Handshake between input stage, decoder and output stage
    typedef struct packed {
        logic valid;
        logic advance;
    } tga_flow_t;

endpackage

`default_nettype wire

@@ sv/tga_psd_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tga_psd_in_reg
    import tga_psd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire tga_in_t s_data,
    input  wire logic    advance,
    output logic         item_valid,
    output tga_in_t      item
);

    logic    valid_reg, valid_next;
    tga_in_t data_reg;

    // Take a new item when empty or when the held one moves on
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

@@ sv/tga_psd_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tga_psd_decode
    import tga_psd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire tga_flow_t flow,
    input  wire tga_in_t   item,
    input  wire tga_cfg_t  cfg,
    output logic           res_valid,
    output tga_out_t       res
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;

    logic                   in_header_reg, in_header_next;
    logic [HDR_CNT_W-1:0]   hdr_cnt_reg, hdr_cnt_next;
    logic [BYTE_W-1:0]      skip_reg, skip_next;
    logic [PIX_BYTES_W-1:0] pix_bytes_reg, pix_bytes_next;
    logic [BYTE_IDX_W-1:0]  byte_idx_reg, byte_idx_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [LINE_W-1:0]      line_reg, line_next;
    logic [BYTE_W-1:0]      part_reg [3];

    // Effective state: restart wipes it before this byte
    logic                   cur_header;
    logic [HDR_CNT_W-1:0]   cur_hdr_cnt;
    logic [BYTE_W-1:0]      cur_skip;
    logic [PIX_BYTES_W-1:0] cur_pix_bytes;
    logic [BYTE_IDX_W-1:0]  cur_byte_idx;
    logic [COL_W-1:0]       cur_col;
    logic [LINE_W-1:0]      cur_line;

    logic                   part_we;
    logic [BYTE_IDX_W-1:0]  part_idx;
    logic [HDR_CNT_W-1:0]   hdr_inc;
    logic [CMP_W-1:0]       col_inc;
    logic [CMP_W-1:0]       col_ext;
    logic                   wrap;
    logic [LINE_W:0]        row;
    logic [BYTE_W-1:0]      b;
    logic                   depth_ok;

    assign b = item.data_byte;

    always_comb begin
        cur_header    = item.restart ? 1'b1           : in_header_reg;
        cur_hdr_cnt   = item.restart ? '0             : hdr_cnt_reg;
        cur_skip      = item.restart ? '0             : skip_reg;
        cur_pix_bytes = item.restart ? PIX_BYTES_BGR  : pix_bytes_reg;
        cur_byte_idx  = item.restart ? '0             : byte_idx_reg;
        cur_col       = item.restart ? '0             : col_reg;
        cur_line      = item.restart ? '0             : line_reg;
    end

    // Column and row arithmetic for the pixel being completed
    assign hdr_inc  = cur_hdr_cnt + 1'b1;
    assign col_ext  = CMP_W'(cur_col);
    assign col_inc  = col_ext + 1'b1;
    assign wrap     = (col_inc >= CMP_W'(cfg.line_width)) ||
                      (col_inc >= CMP_W'(MAX_WIDTH));
    assign row      = {1'b0, cur_line} + {2'b00, cfg.row_offset};
    assign depth_ok = (cur_pix_bytes == PIX_BYTES_BGR) ||
                      (cur_pix_bytes == PIX_BYTES_BGRA);

    always_comb begin
        in_header_next = cur_header;
        hdr_cnt_next   = cur_hdr_cnt;
        skip_next      = cur_skip;
        pix_bytes_next = cur_pix_bytes;
        byte_idx_next  = cur_byte_idx;
        col_next       = cur_col;
        line_next      = cur_line;
        part_we        = 1'b0;
        part_idx       = (cur_byte_idx == 2'd3) ? '0 : cur_byte_idx;
        res_valid      = 1'b0;
        res            = '0;

        if (cur_header) begin
            // Capture ID length and pixel depth from the header
            if (cur_hdr_cnt == HDR_ID_LEN) begin
                skip_next = b;
            end
            if (cur_hdr_cnt == HDR_DEPTH) begin
                if (b[7:3] == 5'd3 || b[7:3] == 5'd4) begin
                    pix_bytes_next = b[5:3];
                end else begin
                    pix_bytes_next = PIX_BYTES_NONE;
                end
            end
            hdr_cnt_next = hdr_inc;
            if (hdr_inc >= HEADER_LEN) begin
                in_header_next = 1'b0;
            end
        end else if (cur_skip != '0) begin
            // Drop ID field bytes
            skip_next = cur_skip - 1'b1;
        end else if (!depth_ok) begin
            res_valid       = 1'b1;
            res.depth_error = 1'b1;
        end else if (({1'b0, cur_byte_idx} + 1'b1) < cur_pix_bytes) begin
            // Hold the byte until the pixel is complete
            part_we       = 1'b1;
            byte_idx_next = cur_byte_idx + 1'b1;
        end else begin
            byte_idx_next = '0;
            res_valid     = 1'b1;
            res.blue      = part_reg[0];
            res.green     = part_reg[1];
            if (cur_pix_bytes == PIX_BYTES_BGRA) begin
                res.red   = part_reg[2];
                res.alpha = b;
            end else begin
                res.red   = b;
                res.alpha = ALPHA_OPAQUE;
            end
            res.pixel_x  = col_ext[PIXEL_X_W-1:0];
            res.pixel_y  = row[LINE_W] ? LINE_MAX : row[LINE_W-1:0];
            res.in_image = row < {1'b0, cfg.image_height};
            res.line_end = wrap;
            // Advance column, wrap to next line
            if (wrap) begin
                col_next = '0;
                if (cur_line != LINE_MAX) begin
                    line_next = cur_line + 1'b1;
                end
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_header_reg <= 1'b1;
            hdr_cnt_reg   <= '0;
            skip_reg      <= '0;
            pix_bytes_reg <= PIX_BYTES_BGR;
            byte_idx_reg  <= '0;
            col_reg       <= '0;
            line_reg      <= '0;
        end else if (flow.valid && flow.advance) begin
            in_header_reg <= in_header_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            skip_reg      <= skip_next;
            pix_bytes_reg <= pix_bytes_next;
            byte_idx_reg  <= byte_idx_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (flow.valid && flow.advance && part_we) begin
            part_reg[part_idx] <= b;
        end
    end

endmodule

`default_nettype wire

@@ sv/tga_psd_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tga_psd_out_reg
    import tga_psd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      item_valid,
    input  wire logic      res_valid,
    input  wire tga_out_t  res,
    output tga_flow_t      flow,
    output logic           m_valid,
    input  wire logic      m_ready,
    output tga_out_t       m_data
);

    logic     valid_reg, valid_next;
    tga_out_t data_reg;
    logic     advance;

    // Move the held item on when the result slot is free or being taken
    assign advance      = !valid_reg || m_ready;
    assign flow.valid   = item_valid;
    assign flow.advance = advance;

    always_comb begin
        valid_next = valid_reg;
        if (item_valid && advance) begin
            valid_next = res_valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid && advance && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

@@ sv/tga_pixel_stream_decoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   tga_in_t  (data_byte, restart)
// m_        out        m_valid / m_ready   tga_out_t (pixel, position, flags)
// cfg_      in         cfg_wr_en           cfg_index, cfg_wr_data
//
// One byte per cycle sustained while m_ready stays high; each byte is held in the
// input register and leaves its result, if any, in the output register.
// The per-byte update of header, skip, column and line counters sits between
// those two registers. Reset (aresetn low, synchronous) returns the decoder to
// header capture and loads 640 x 480 with row offset 0. A stalled m_ready holds
// the result and the pending byte; s_ready drops only while both are full.

module tga_pixel_stream_decoder_top
    import tga_psd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire tga_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output tga_out_t                   m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    tga_cfg_t  cfg_reg;
    tga_in_t   item;
    logic      item_valid;
    tga_flow_t flow;
    logic      res_valid;
    tga_out_t  res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_width   <= LINE_WIDTH_RST;
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
            cfg_reg.row_offset   <= ROW_OFFSET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LINE_WIDTH:   cfg_reg.line_width   <= cfg_wr_data;
                CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_wr_data;
                CFG_ROW_OFFSET:   cfg_reg.row_offset   <= cfg_wr_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    tga_psd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (flow.advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tga_psd_decode #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .flow      (flow),
        .item      (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    tga_psd_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .res_valid  (res_valid),
        .res        (res),
        .flow       (flow),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tga_psd_pkg::*;

    localparam int COL_LIMIT    = 4096;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 270;
    localparam int SHORT_PIXELS = 24;
    localparam int MAX_REPORTS  = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    tga_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    tga_out_t              m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    // Pixel decoder state mirrored from the stream seen so far
    logic [DIM_W-1:0]    line_width_reg;
    logic [DIM_W-1:0]    image_height_reg;
    logic [OFFSET_W-1:0] row_offset_reg;
    bit                  hdr_active;
    int unsigned         hdr_pos;
    int unsigned         id_skip;
    int unsigned         bytes_per_pixel;
    int unsigned         pix_pos;
    logic [BYTE_W-1:0]   pix_part [3];
    int unsigned         col_pos;
    int unsigned         line_pos;

    tga_out_t    pixel_q [$];
    tga_out_t    pixel_want;
    int unsigned bytes_sent;
    int unsigned error_count;
    bit          sender_gaps_on;
    bit          receiver_stalls_on;

    tga_pixel_stream_decoder_top #(
        .MAX_WIDTH(COL_LIMIT)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Return the decoder to header capture; registers are kept
    function automatic void clear_decoder();
        hdr_active      = 1'b1;
        hdr_pos         = 0;
        id_skip         = 0;
        bytes_per_pixel = PIX_BYTES_BGR;
        pix_pos         = 0;
        pix_part        = '{default: '0};
        col_pos         = 0;
        line_pos        = 0;
    endfunction

    // Advance the decoder by one byte; returns 1 when a pixel result is due
    function automatic bit decode_byte(input tga_in_t item, output tga_out_t res);
        int unsigned depth_bytes;
        int unsigned row;
        bit          wrap;
        res = '0;
        if (item.restart) begin
            clear_decoder();
        end
        // Capture ID length and depth from the header
        if (hdr_active) begin
            if (hdr_pos == HDR_ID_LEN) begin
                id_skip = item.data_byte;
            end
            if (hdr_pos == HDR_DEPTH) begin
                depth_bytes = item.data_byte / 8;
                bytes_per_pixel = (depth_bytes == PIX_BYTES_BGR ||
                                   depth_bytes == PIX_BYTES_BGRA) ?
                                  depth_bytes : PIX_BYTES_NONE;
            end
            hdr_pos++;
            if (hdr_pos >= HEADER_LEN) begin
                hdr_active = 1'b0;
            end
            return 1'b0;
        end
        // Drop the ID field
        if (id_skip > 0) begin
            id_skip--;
            return 1'b0;
        end
        // Flag every data byte of an unsupported depth
        if (bytes_per_pixel != PIX_BYTES_BGR && bytes_per_pixel != PIX_BYTES_BGRA) begin
            res.depth_error = 1'b1;
            return 1'b1;
        end
        // Hold the leading bytes of the pixel
        if (pix_pos + 1 < bytes_per_pixel) begin
            pix_part[pix_pos] = item.data_byte;
            pix_pos++;
            return 1'b0;
        end
        pix_pos   = 0;
        res.blue  = pix_part[0];
        res.green = pix_part[1];
        if (bytes_per_pixel == PIX_BYTES_BGRA) begin
            res.red   = pix_part[2];
            res.alpha = item.data_byte;
        end else begin
            res.red   = item.data_byte;
            res.alpha = ALPHA_OPAQUE;
        end
        row = line_pos + row_offset_reg;
        res.pixel_x  = PIXEL_X_W'(col_pos);
        res.pixel_y  = (row > LINE_MAX) ? LINE_MAX : PIXEL_Y_W'(row);
        res.in_image = (row < image_height_reg);
        // Wrap the column at the line width or the hard column limit
        wrap = (col_pos + 1 >= line_width_reg) || (col_pos + 1 >= COL_LIMIT);
        if (wrap) begin
            col_pos = 0;
            if (line_pos < LINE_MAX) begin
                line_pos++;
            end
        end else begin
            col_pos++;
        end
        res.line_end = wrap;
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string field, input int unsigned got,
                               input int unsigned wanted);
        if (got != wanted) begin
            flag_error($sformatf("%s is %0d, %0d expected", field, got, wanted));
        end
    endtask

    // Send one byte; entered and left at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic restart);
        tga_in_t  item;
        tga_out_t res;
        int       gap;
        item.data_byte = value;
        item.restart   = restart;
        gap = sender_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        // Predict at the falling edge so no result can race the expectation
        @(negedge aclk);
        if (decode_byte(item, res)) begin
            pixel_q.push_back(res);
        end
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_header(input logic restart, input logic [BYTE_W-1:0] id_len,
                               input logic [BYTE_W-1:0] depth);
        for (int i = 0; i < HEADER_LEN; i++) begin
            if (i == HDR_ID_LEN) begin
                send_byte(id_len, restart);
            end else if (i == HDR_DEPTH) begin
                send_byte(depth, 1'b0);
            end else begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    // Drop valid and wait until every pixel is back and the pipe is empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write all three registers on consecutive cycles; call only when idle
    task automatic load_config(input logic [DIM_W-1:0] width,
                               input logic [DIM_W-1:0] height,
                               input logic [OFFSET_W-1:0] offset);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_LINE_WIDTH;
        cfg_wr_data <= width;
        @(negedge aclk);
        cfg_index   <= CFG_IMAGE_HEIGHT;
        cfg_wr_data <= height;
        @(negedge aclk);
        cfg_index   <= CFG_ROW_OFFSET;
        cfg_wr_data <= CFG_DATA_W'(offset);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        line_width_reg   = width;
        image_height_reg = height;
        row_offset_reg   = offset;
    endtask

    task automatic test_directed_stream();
        // 24-bit image straight after reset, no ID field, extreme pixels
        send_header(1'b0, 8'd0, 8'd24);
        repeat (3) send_byte(8'h00, 1'b0);
        repeat (3) send_byte(8'hFF, 1'b0);
        // Abandon a half pixel, restart into a 32-bit image with an ID field
        send_byte(8'h5A, 1'b0);
        send_header(1'b1, 8'd2, 8'd32);
        send_random(2);
        repeat (4) send_byte(8'h00, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);
        // Unsupported depths flag each data byte
        send_header(1'b1, 8'd0, 8'd16);
        send_random(2);
        send_header(1'b1, 8'd1, 8'hFF);
        send_random(3);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        // Zero width wraps every pixel; rows start far down and miss the image
        load_config(13'd0, 13'd0, 12'd4095);
        send_header(1'b1, 8'd0, 8'd24);
        send_random(9);
        wait_idle();
        load_config(13'd4096, 13'd8191, 12'd0);
        send_header(1'b1, 8'd0, 8'd32);
        send_random(12);
        wait_idle();
    endtask

    task automatic test_column_limit();
        // Width above the column limit: a short run must not wrap early
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        load_config(13'd8191, 13'd1, 12'd0);
        send_header(1'b1, 8'd0, 8'd24);
        send_random(3 * SHORT_PIXELS);
        wait_idle();
    endtask

    task automatic test_narrow_lines();
        // One pixel per line, starting from the deepest row offset
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        load_config(13'd1, 13'd8191, 12'd4095);
        send_header(1'b1, 8'd0, 8'd24);
        send_random(3 * SHORT_PIXELS);
        wait_idle();
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    task automatic test_random_streams();
        int unsigned       stop_at;
        int unsigned       kind;
        int unsigned       id_len;
        int unsigned       pixels;
        logic [BYTE_W-1:0] depth;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [OFFSET_W-1:0] offset;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            // Reprogram now and then, only with nothing in flight
            if ($urandom_range(0, 4) == 0) begin
                wait_idle();
                case ($urandom_range(0, 5))
                    0:       width = 13'd0;
                    1:       width = 13'd8191;
                    2:       width = 13'd4096;
                    default: width = 13'($urandom_range(1, 8));
                endcase
                case ($urandom_range(0, 4))
                    0:       height = 13'd0;
                    1:       height = 13'd8191;
                    default: height = 13'($urandom_range(0, 12));
                endcase
                offset = ($urandom_range(0, 5) == 0) ? 12'd4095 : 12'($urandom_range(0, 6));
                load_config(width, height, offset);
            end
            sender_gaps_on     = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
            kind   = $urandom_range(0, 9);
            id_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 3);
            if (kind < 7) begin
                // Well-formed image, sometimes cut off inside the last pixel
                depth  = {($urandom_range(0, 1) != 0) ? 5'd4 : 5'd3, 3'($urandom_range(0, 7))};
                pixels = $urandom_range(1, 24);
                send_header(1'b1, 8'(id_len), depth);
                send_random(id_len);
                send_random(pixels * (depth / 8) - ((kind == 6) ? 1 : 0));
            end else if (kind < 9) begin
                // Any depth byte, mostly unsupported ones
                depth = 8'($urandom_range(0, 255));
                send_header(1'b1, 8'(id_len), depth);
                send_random(id_len + $urandom_range(1, 8));
            end else begin
                // Noise with restarts landing anywhere
                repeat ($urandom_range(1, 12)) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    // Compare each accepted pixel with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                flag_error("pixel result with none expected");
            end else begin
                pixel_want = pixel_q.pop_front();
                check_field("pixel_x", m_data.pixel_x, pixel_want.pixel_x);
                check_field("pixel_y", m_data.pixel_y, pixel_want.pixel_y);
                check_field("red", m_data.red, pixel_want.red);
                check_field("green", m_data.green, pixel_want.green);
                check_field("blue", m_data.blue, pixel_want.blue);
                check_field("alpha", m_data.alpha, pixel_want.alpha);
                check_field("in_image", m_data.in_image, pixel_want.in_image);
                check_field("line_end", m_data.line_end, pixel_want.line_end);
                check_field("depth_error", m_data.depth_error, pixel_want.depth_error);
            end
        end
    end

    // Result side: stall at random before each item while stalls are enabled
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = receiver_stalls_on ? $urandom_range(0, 7) : 0;
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data             = '0;
        cfg_wr_en          = 1'b0;
        cfg_index          = CFG_LINE_WIDTH;
        cfg_wr_data        = '0;
        bytes_sent         = 0;
        error_count        = 0;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        line_width_reg     = LINE_WIDTH_RST;
        image_height_reg   = IMAGE_HEIGHT_RST;
        row_offset_reg     = ROW_OFFSET_RST;
        clear_decoder();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_stream();
        test_config_extremes();
        test_column_limit();
        test_narrow_lines();
        test_random_streams();
        wait_idle();

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/tga_psd_pkg.sv
sv/tga_psd_in_reg.sv
sv/tga_psd_decode.sv
sv/tga_psd_out_reg.sv
sv/tga_pixel_stream_decoder_top.sv
verif/testbench.sv
